[hdl/virtio_net_register_block_unit_defines.svh]
// assertion macros shared by the checker of the virtio net register block
// no dependencies; expects clk and rst_n in the scope of use
`ifndef VIRTIO_NET_REGISTER_BLOCK_UNIT_DEFINES_SVH
`define VIRTIO_NET_REGISTER_BLOCK_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define VNR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define VNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vnr_pkg.sv]
// shared types, codes and helpers of the virtio net register block
// no dependencies
package vnr_pkg;

  // ring sizes as reported by the queue size register
  localparam logic [15:0] RX_RING_ENTRIES   = 16'd4096;
  localparam logic [15:0] TX_RING_ENTRIES   = 16'd4096;
  localparam logic [15:0] CTRL_RING_ENTRIES = 16'd64;
  localparam int          PAGE_SHIFT_BITS   = 12;

  // bus operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_IRQ   = 2'd2;

  // i/o window offsets
  localparam logic [4:0] P_HOSTF    = 5'd0;
  localparam logic [4:0] P_GUESTF   = 5'd4;
  localparam logic [4:0] P_PFN      = 5'd8;
  localparam logic [4:0] P_QSIZE    = 5'd12;
  localparam logic [4:0] P_QSEL     = 5'd14;
  localparam logic [4:0] P_NOTIFY   = 5'd16;
  localparam logic [4:0] P_STATUS   = 5'd18;
  localparam logic [4:0] P_ISR      = 5'd19;
  localparam logic [4:0] P_MAC      = 5'd20;
  localparam logic [4:0] P_MAC_LAST = 5'd25;

  // event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_TX     = 3'd1;
  localparam logic [2:0] EV_RX     = 3'd2;
  localparam logic [2:0] EV_CTRL   = 3'd3;
  localparam logic [2:0] EV_SETUP  = 3'd4;
  localparam logic [2:0] EV_RESET  = 3'd5;
  localparam logic [2:0] EV_IRQLOW = 3'd6;

  // queue indexes
  localparam logic [1:0] Q_RX   = 2'd0;
  localparam logic [1:0] Q_TX   = 2'd1;
  localparam logic [1:0] Q_CTRL = 2'd2;

  // configuration register indexes (paddr bit 3)
  localparam logic REG_MAC   = 1'b0;
  localparam logic REG_HOSTF = 1'b1;

  localparam logic [31:0] HOSTF_RESET = 32'h0000_0020;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  port_offset;
    logic [2:0]  access_length;
    logic [31:0] write_data;
  } vnr_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic [2:0]  event_code;
    logic [1:0]  event_queue;
    logic [43:0] page_address;
    logic        irq_line;
  } vnr_result_t;

  function automatic logic [31:0] len_mask(input logic [2:0] len);
    logic [31:0] m;
    case (len)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] ring_entries(input logic [1:0] q);
    logic [15:0] n;
    case (q)
      Q_RX:    n = RX_RING_ENTRIES;
      Q_TX:    n = TX_RING_ENTRIES;
      default: n = CTRL_RING_ENTRIES;
    endcase
    return n;
  endfunction

endpackage

[hdl/vnr_cfg_regs.sv]
// apb configuration registers: station mac and host feature word
// depends on vnr_pkg
module vnr_cfg_regs
  import vnr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic [47:0] mac_address,
  output logic [31:0] host_feature_bits
);

  logic [47:0] mac_r;
  logic [31:0] hostf_r;
  logic        wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r   <= '0;
      hostf_r <= HOSTF_RESET;
    end else if (wr_en) begin
      case (paddr[3])
        REG_MAC:   mac_r   <= pwdata[47:0];
        REG_HOSTF: hostf_r <= pwdata[31:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_MAC:   prdata = {16'd0, mac_r};
      REG_HOSTF: prdata = {32'd0, hostf_r};
      default:   prdata = '0;
    endcase
  end

  assign mac_address       = mac_r;
  assign host_feature_bits = hostf_r;

endmodule

[hdl/vnr_core.sv]
// device state registers and the single-pass access decode
// depends on vnr_pkg
module vnr_core
  import vnr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  vnr_item_t   item,
  input  logic [47:0] mac_address,
  input  logic [31:0] host_feature_bits,
  output vnr_result_t result
);

  logic [31:0] guestf_r, guestf_nxt;
  logic [15:0] qsel_r, qsel_nxt;
  logic [31:0] frame_r [3];
  logic [31:0] frame_nxt [3];
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  isr_r, isr_nxt;
  logic        irq_r, irq_nxt;

  logic        len_ok;
  logic        sel_ok;
  logic [1:0]  sel_q;
  logic [31:0] wdata;
  logic [2:0]  mac_off;
  logic [63:0] mac_sh;
  logic [31:0] rd;
  vnr_result_t res;

  assign len_ok = (item.access_length == 3'd1) || (item.access_length == 3'd2) ||
                  (item.access_length == 3'd4);
  assign sel_ok = (qsel_r <= 16'd2);
  assign sel_q  = qsel_r[1:0];
  assign wdata  = item.write_data & len_mask(item.access_length);
  assign mac_off = 3'(item.port_offset - P_MAC);
  assign mac_sh  = {16'd0, mac_address} >> {mac_off, 3'b000};

  always_comb begin
    guestf_nxt = guestf_r;
    qsel_nxt   = qsel_r;
    frame_nxt  = frame_r;
    status_nxt = status_r;
    isr_nxt    = isr_r;
    irq_nxt    = irq_r;
    rd         = '0;
    res        = '0;

    if (item.operation == OP_IRQ) begin
      isr_nxt = 8'd1;
      irq_nxt = 1'b1;
    end else if (item.operation != OP_READ && item.operation != OP_WRITE || !len_ok) begin
      res.access_error = 1'b1;
    end else if (item.operation == OP_READ) begin
      case (item.port_offset)
        P_HOSTF: rd = host_feature_bits;
        P_GUESTF: begin
          if (item.access_length != 3'd4) res.access_error = 1'b1;
          else rd = guestf_r;
        end
        P_PFN: begin
          if (item.access_length != 3'd4 || !sel_ok) res.access_error = 1'b1;
          else rd = frame_r[sel_q];
        end
        P_QSIZE: begin
          if (item.access_length != 3'd2 || !sel_ok) res.access_error = 1'b1;
          else rd = {16'd0, ring_entries(sel_q)};
        end
        P_STATUS: begin
          if (item.access_length != 3'd1) res.access_error = 1'b1;
          else rd = {24'd0, status_r};
        end
        P_ISR: begin
          // read to clear, drops the line
          rd             = {24'd0, isr_r};
          isr_nxt        = '0;
          irq_nxt        = 1'b0;
          res.event_code = EV_IRQLOW;
        end
        default: begin
          if (item.port_offset inside {[P_MAC:P_MAC_LAST]}) rd = mac_sh[31:0];
          else res.access_error = 1'b1;
        end
      endcase
      res.read_data = rd & len_mask(item.access_length);
    end else begin
      case (item.port_offset)
        P_GUESTF: begin
          if (item.access_length != 3'd4) res.access_error = 1'b1;
          else guestf_nxt = wdata;
        end
        P_PFN: begin
          if (item.access_length != 3'd4 || !sel_ok) begin
            res.access_error = 1'b1;
          end else begin
            frame_nxt[sel_q]  = wdata;
            res.event_code    = EV_SETUP;
            res.event_queue   = sel_q;
            res.page_address  = 44'(wdata) << PAGE_SHIFT_BITS;
          end
        end
        P_QSEL: begin
          qsel_nxt = wdata[15:0];
          if (wdata[15:0] > 16'd2) res.access_error = 1'b1;
        end
        P_NOTIFY: begin
          case (wdata[15:0])
            16'd0: begin res.event_code = EV_RX;   res.event_queue = Q_RX;   end
            16'd1: begin res.event_code = EV_TX;   res.event_queue = Q_TX;   end
            16'd2: begin res.event_code = EV_CTRL; res.event_queue = Q_CTRL; end
            default: res.access_error = 1'b1;
          endcase
        end
        P_STATUS: begin
          status_nxt = wdata[7:0];
          if (wdata[7:0] == 8'd0) begin
            frame_nxt[0]   = '0;
            frame_nxt[1]   = '0;
            frame_nxt[2]   = '0;
            isr_nxt        = '0;
            irq_nxt        = 1'b0;
            res.event_code = EV_RESET;
          end
        end
        P_ISR: isr_nxt = wdata[7:0];
        default: res.access_error = 1'b1;
      endcase
    end

    res.irq_line = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guestf_r   <= '0;
      qsel_r     <= '0;
      frame_r[0] <= '0;
      frame_r[1] <= '0;
      frame_r[2] <= '0;
      status_r   <= '0;
      isr_r      <= '0;
      irq_r      <= 1'b0;
    end else if (fire) begin
      guestf_r <= guestf_nxt;
      qsel_r   <= qsel_nxt;
      frame_r  <= frame_nxt;
      status_r <= status_nxt;
      isr_r    <= isr_nxt;
      irq_r    <= irq_nxt;
    end
  end

  assign result = res;

endmodule

[hdl/virtio_net_register_block_unit.sv]
// top level of the legacy virtio net register block: input register, decode, result register
// a transfer fills the input register, then out_valid rises as the result register loads
// throughput: one access per cycle with no out_stall; a single decode pass between registers
// two-entry pipe: in_stall is high only while both registers hold data and out_stall is high
// reset (synchronous, rst_n low): pipe empty, device state zero, host features 0x20, mac 0
// no clearing pass after reset: the block takes transfers on the first cycle after reset
module virtio_net_register_block_unit
  import vnr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // access input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_port_offset,
  input  logic [2:0]  in_access_length,
  input  logic [31:0] in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_access_error,
  output logic [2:0]  out_event_code,
  output logic [1:0]  out_event_queue,
  output logic [43:0] out_page_address,
  output logic        out_irq_line,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  vnr_item_t   item_r;
  logic        item_valid_r;
  vnr_result_t res_r;
  logic        out_valid_r;

  vnr_result_t res_comb;
  logic [47:0] mac_address;
  logic [31:0] host_feature_bits;
  logic        out_free;
  logic        fire;
  logic        in_xfer;

  // the result register can take a new value when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // the held access is decoded and commits its state update this cycle
  assign fire     = item_valid_r && out_free;
  // the input register frees up whenever its access moves on
  assign in_stall = item_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign pready   = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_xfer) begin
      item_valid_r <= 1'b1;
    end else if (fire) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.operation     <= in_operation;
      item_r.port_offset   <= in_port_offset;
      item_r.access_length <= in_access_length;
      item_r.write_data    <= in_write_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_comb;
    end
  end

  vnr_cfg_regs u_cfg (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .mac_address       (mac_address),
    .host_feature_bits (host_feature_bits)
  );

  vnr_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .fire              (fire),
    .item              (item_r),
    .mac_address       (mac_address),
    .host_feature_bits (host_feature_bits),
    .result            (res_comb)
  );

  assign out_valid        = out_valid_r;
  assign out_read_data    = res_r.read_data;
  assign out_access_error = res_r.access_error;
  assign out_event_code   = res_r.event_code;
  assign out_event_queue  = res_r.event_queue;
  assign out_page_address = res_r.page_address;
  assign out_irq_line     = res_r.irq_line;

endmodule

[hdl/vnr_checker.sv]
// port-level checker of the virtio net register block, bound to the top level
// depends on vnr_pkg and virtio_net_register_block_unit_defines.svh
`include "virtio_net_register_block_unit_defines.svh"

module vnr_checker
  import vnr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_read_data,
  input logic        out_access_error,
  input logic [2:0]  out_event_code,
  input logic [43:0] out_page_address,
  input logic        out_irq_line
);

  logic [80:0] payload;
  logic        irq_low_ev;
  logic        no_setup;
  logic        err_shown;

  assign payload    = {out_read_data, out_access_error, out_event_code, out_page_address,
                       out_irq_line};
  assign irq_low_ev = out_valid && (out_event_code == EV_IRQLOW);
  assign no_setup   = out_valid && (out_event_code != EV_SETUP);
  assign err_shown  = out_valid && out_access_error;

  // a stalled result keeps its payload
  `VNR_ASSERT_NEXT(a_hold, out_valid && out_stall, $stable(payload), "stalled result changed")

  // isr read always leaves the line low
  `VNR_ASSERT_SAME(a_irq_low, irq_low_ev, !out_irq_line, "irq high after isr read")

  // ring base only on queue set-up
  `VNR_ASSERT_SAME(a_page, no_setup, out_page_address == '0, "page address without set-up")

  // a rejected access never raises an event
  `VNR_ASSERT_SAME(a_err_ev, err_shown, out_event_code == EV_NONE, "event on failed access")

endmodule

bind virtio_net_register_block_unit vnr_checker u_vnr_checker (.*);
